>>> rtl/trm_pkg.sv
// Shared types and codes for the two-register machine executor.
package trm_pkg;

  localparam logic [3:0] FUNC_NOP      = 4'd0;
  localparam logic [3:0] FUNC_LOAD_IMM = 4'd1;
  localparam logic [3:0] FUNC_SWAP     = 4'd2;
  localparam logic [3:0] FUNC_LOAD_MEM = 4'd3;
  localparam logic [3:0] FUNC_STORE    = 4'd4;
  localparam logic [3:0] FUNC_JUMPIF   = 4'd5;
  localparam logic [3:0] FUNC_ROTATE   = 4'd6;
  localparam logic [3:0] FUNC_FLIP     = 4'd7;
  localparam logic [3:0] FUNC_UNRES_LB = 4'd8;
  localparam logic [3:0] FUNC_UNRES_MC = 4'd9;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_RANGE  = 2'd1;
  localparam logic [1:0] STATUS_LABEL  = 2'd2;
  localparam logic [1:0] STATUS_MACRO  = 2'd3;

  localparam logic [63:0] CHAR_PORT = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WORD_PORT = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [7:0]  CHAR_LIMIT = 8'h80;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] next_index;
    logic        halted;
    logic        char_in_taken;
    logic        char_out_valid;
    logic [6:0]  char_out;
    logic        word_out_valid;
    logic [63:0] word_out;
    logic [63:0] reg_a_now;
    logic [63:0] reg_b_now;
  } trm_res_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] idx;
    logic        mem_we;
    trm_res_t    res;
  } trm_exec_t;

endpackage

>>> rtl/trm_ram.sv
// Generic single-port-write, registered-read RAM.
module trm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/trm_exec.sv
// Instruction execute logic: next register state, memory write and result.
module trm_exec #(
  parameter int MEM_WORDS = 65536
) (
  input  logic [3:0]         func,
  input  logic [63:0]        immediate,
  input  logic [7:0]         char_in,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  input  logic [63:0]        idx,
  input  logic [63:0]        rdata,
  input  logic [31:0]        prog_len,
  output trm_pkg::trm_exec_t ex
);
  import trm_pkg::*;

  logic [63:0] a_nxt;
  logic [63:0] b_nxt;
  logic [63:0] next;
  logic [63:0] inc;
  logic [1:0]  status;
  logic        taken;
  logic        cvalid;
  logic [6:0]  cval;
  logic        wvalid;
  logic [63:0] wval;
  logic        mem_we;
  logic        a_in_mem;
  logic        b_in_mem;

  assign inc      = idx + 64'd1;
  assign a_in_mem = a < 64'(MEM_WORDS);
  assign b_in_mem = b < 64'(MEM_WORDS);

  always_comb begin
    a_nxt  = a;
    b_nxt  = b;
    next   = inc;
    status = STATUS_OK;
    taken  = 1'b0;
    cvalid = 1'b0;
    cval   = 7'd0;
    wvalid = 1'b0;
    wval   = 64'd0;
    mem_we = 1'b0;
    case (func)
      FUNC_LOAD_IMM: a_nxt = immediate;
      FUNC_SWAP: begin
        a_nxt = b;
        b_nxt = a;
      end
      FUNC_LOAD_MEM: begin
        if (a == WORD_PORT) begin
          a_nxt = 64'd0;
        end else if (a == CHAR_PORT) begin
          taken = 1'b1;
          a_nxt = (char_in < CHAR_LIMIT) ? {56'd0, char_in} : 64'd0;
        end else if (a_in_mem) begin
          a_nxt = rdata;
        end else begin
          a_nxt  = 64'd0;
          status = STATUS_RANGE;
        end
      end
      FUNC_STORE: begin
        if (b == WORD_PORT) begin
          wvalid = 1'b1;
          wval   = a;
        end else if (b == CHAR_PORT) begin
          if (a < 64'(CHAR_LIMIT)) begin
            cvalid = 1'b1;
            cval   = a[6:0];
          end
        end else if (b_in_mem) begin
          mem_we = 1'b1;
        end else begin
          status = STATUS_RANGE;
        end
      end
      FUNC_JUMPIF: begin
        if (a[0]) begin
          next  = b;
          b_nxt = inc;
        end
      end
      FUNC_ROTATE:   a_nxt = {a[0], a[63:1]};
      FUNC_FLIP:     a_nxt = {a[63:1], ~a[0]};
      FUNC_UNRES_LB: status = STATUS_LABEL;
      FUNC_UNRES_MC: status = STATUS_MACRO;
      default: ;
    endcase
    if (status != STATUS_OK) begin
      next = idx;
    end
  end

  assign ex.a                  = a_nxt;
  assign ex.b                  = b_nxt;
  assign ex.idx                = next;
  assign ex.mem_we             = mem_we;
  assign ex.res.status         = status;
  assign ex.res.next_index     = next;
  assign ex.res.halted         = (status != STATUS_OK) || (next >= {32'd0, prog_len});
  assign ex.res.char_in_taken  = taken;
  assign ex.res.char_out_valid = cvalid;
  assign ex.res.char_out       = cval;
  assign ex.res.word_out_valid = wvalid;
  assign ex.res.word_out       = wval;
  assign ex.res.reg_a_now      = a_nxt;
  assign ex.res.reg_b_now      = b_nxt;

endmodule

>>> rtl/two_register_machine_executor.sv
// Two-register machine executor: one instruction per transfer, with output register.
// Each instruction passes a read stage and then an execute stage: in the read stage the
// data word at address A is read from the synchronous data memory, in the execute stage
// the instruction executes and its result goes to the output register. The next
// instruction is taken in the cycle its predecessor executes, unless the output register
// stalls; no instruction is taken while one is in the read stage, since that read must see
// the A left by the previous instruction. The data memory is not cleared at reset; a load of
// a word never stored returns an undefined value. program_length must be written
// through cfg_we/cfg_wdata, by the user while the block is idle; nothing enforces it.
module two_register_machine_executor #(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_func,
  input  logic [63:0] in_immediate,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_next_index,
  output logic        out_halted,
  output logic        out_char_in_taken,
  output logic        out_char_out_valid,
  output logic [6:0]  out_char_out,
  output logic        out_word_out_valid,
  output logic [63:0] out_word_out,
  output logic [63:0] out_reg_a_now,
  output logic [63:0] out_reg_b_now
);
  import trm_pkg::*;

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [31:0] plen_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] idx_r;
  logic        s1_v_r;
  logic        s2_v_r;
  logic [3:0]  func_r;
  logic [63:0] imm_r;
  logic [7:0]  ch_r;
  logic        out_v_r;
  trm_res_t    res_r;

  logic        in_xfer;
  logic        out_free;
  logic        s2_go;
  logic        mem_we;
  logic [63:0] rdata;
  trm_exec_t   ex;

  assign out_free = !out_v_r || !out_stall;
  assign s2_go    = s2_v_r && out_free;
  assign in_stall = s1_v_r || (s2_v_r && !out_free);
  assign in_xfer  = in_valid && !in_stall;
  assign mem_we   = s2_go && ex.mem_we;

  trm_ram #(
    .WIDTH(64),
    .DEPTH(MEM_WORDS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(b_r[AW-1:0]),
    .wdata(a_r),
    .re   (s1_v_r),
    .raddr(a_r[AW-1:0]),
    .rdata(rdata)
  );

  trm_exec #(
    .MEM_WORDS(MEM_WORDS)
  ) u_exec (
    .func     (func_r),
    .immediate(imm_r),
    .char_in  (ch_r),
    .a        (a_r),
    .b        (b_r),
    .idx      (idx_r),
    .rdata    (rdata),
    .prog_len (plen_r),
    .ex       (ex)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      a_r     <= '0;
      b_r     <= '0;
      idx_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        plen_r <= cfg_wdata;
      end
      s1_v_r <= in_xfer;
      if (s1_v_r) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        a_r     <= ex.a;
        b_r     <= ex.b;
        idx_r   <= ex.idx;
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_func;
      imm_r  <= in_immediate;
      ch_r   <= in_char_in;
    end
    if (s2_go) begin
      res_r <= ex.res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = res_r.status;
  assign out_next_index     = res_r.next_index;
  assign out_halted         = res_r.halted;
  assign out_char_in_taken  = res_r.char_in_taken;
  assign out_char_out_valid = res_r.char_out_valid;
  assign out_char_out       = res_r.char_out;
  assign out_word_out_valid = res_r.word_out_valid;
  assign out_word_out       = res_r.word_out;
  assign out_reg_a_now      = res_r.reg_a_now;
  assign out_reg_b_now      = res_r.reg_b_now;

`ifndef SYNTH
  a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_v_r && s2_v_r))
    else $error("read and execute stages both occupied");

  a_read_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("read stage did not advance to execute");

  a_write_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (s2_v_r && out_free && !s1_v_r))
    else $error("memory write outside execute");

  a_fail_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.status != STATUS_OK)) |-> res_r.halted)
    else $error("failing instruction not reported as halted");
`endif

endmodule
